// File: src/fpidpwm_pkg.sv
// Shared types, codes and constants of the filtered PID controller with PWM mapping.
`timescale 1ns / 1ps

package fpidpwm_pkg;

	// Field widths fixed by the interface.
	localparam int COEF_W     = 32;
	localparam int SETPOINT_W = 9;
	localparam int ANGLE_W    = 9;
	localparam int PWM_W      = 12;
	localparam int DIR_W      = 2;
	localparam int ERR_W      = 10;
	localparam int HIST_FRAC  = 16;
	localparam int DIGIT_W    = 4;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Default values of the top level parameters.
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int DRIVE_LIMIT_DEF    = 4095;

	// Register values after reset.
	localparam logic [SETPOINT_W-1:0]    SETPOINT_RST = 9'd330;
	localparam logic signed [COEF_W-1:0] COEF_B0_RST  = -32'sd2247266;
	localparam logic signed [COEF_W-1:0] COEF_B1_RST  = 32'sd4085826;
	localparam logic signed [COEF_W-1:0] COEF_B2_RST  = -32'sd1838560;
	localparam logic signed [COEF_W-1:0] COEF_A1_RST  = -32'sd119145;
	localparam logic signed [COEF_W-1:0] COEF_A2_RST  = 32'sd53609;
	localparam logic [PWM_W-1:0]         PWM_MIN_RST  = 12'd2457;
	localparam logic [PWM_W-1:0]         PWM_MAX_RST  = 12'd4095;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT = 3'd0,
		REG_COEF_B0  = 3'd1,
		REG_COEF_B1  = 3'd2,
		REG_COEF_B2  = 3'd3,
		REG_COEF_A1  = 3'd4,
		REG_COEF_A2  = 3'd5,
		REG_PWM_MIN  = 3'd6,
		REG_PWM_MAX  = 3'd7
	} cfg_reg_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_STOP = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	// Terms of the difference equation, in the order they are accumulated.
	typedef enum logic [2:0] {
		TERM_B0,
		TERM_B1,
		TERM_B2,
		TERM_A1,
		TERM_A2
	} term_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_LAST_ADD,
		ST_CLAMP,
		ST_SCALE,
		ST_START,
		ST_DIVIDE,
		ST_DONE
	} state_t;

endpackage

// File: src/fpidpwm_sdiv.sv
// Bit-serial restoring divider of an unsigned value by a fixed divisor.
`timescale 1ns / 1ps

module fpidpwm_sdiv #(
	parameter int DVD_W   = 24,
	parameter int DIVISOR = 4095,
	parameter int REM_W   = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);

	localparam int CntW = $clog2(DVD_W);
	localparam logic [REM_W:0] Dv = (REM_W + 1)'(DIVISOR);

	logic [DVD_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W:0]   trial;
	logic [REM_W:0]   diff;
	logic             ge;

	// One quotient bit per cycle; the dividend register fills with quotient bits.
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - Dv;
	assign ge    = (trial >= Dv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

// File: src/filtered_pid_pwm_controller.sv
// Top level of the filtered PID controller with PWM duty mapping.
`timescale 1ns / 1ps

// Usage
// One angle sample enters per transaction on the input channel (in_valid, in_ready,
// angle). The block forms the error against the setpoint register, evaluates the
// second-order difference equation with one shared 32 by 5 bit multiplier that
// consumes a 4-bit digit of the error or history per cycle, clamps the result and
// maps its magnitude onto a PWM duty with a bit-serial divider.
// Each sample runs through the multiply loop over the digits of three error words and
// two history words of HistW bits (29 bits at the default limit), then the final
// add, clamping and scaling, the divider with one quotient bit per dividend bit (24
// at the default limit), and a last step that collects the quotient and loads the
// output register. The block takes the next sample only once the result has gone to
// the output register, so it never works on two samples at once.
// The result (direction, duty, drive) sits in an output register until the output
// transaction completes; a new sample is accepted while that result still waits, but
// the next result is held inside until the output register frees.
// Reset clears the error and output history and loads the register defaults.
// Configuration writes are taken at any cycle with cfg_wr_en high and are meant to
// happen only while the block is idle.

module filtered_pid_pwm_controller #(
	parameter int COEF_FRAC_BITS = fpidpwm_pkg::COEF_FRAC_BITS_DEF,
	parameter int DRIVE_LIMIT    = fpidpwm_pkg::DRIVE_LIMIT_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_wr_en,
	input  logic [fpidpwm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [fpidpwm_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [fpidpwm_pkg::ANGLE_W-1:0]           angle,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [fpidpwm_pkg::DIR_W-1:0]             direction,
	output logic [fpidpwm_pkg::PWM_W-1:0]             duty,
	output logic signed [$clog2(DRIVE_LIMIT + 1):0]   drive
);

	// Width of the drive magnitude and of the Q.16 history words.
	localparam int MagW   = $clog2(DRIVE_LIMIT + 1);
	localparam int DriveW = MagW + 1;
	localparam int HistW  = MagW + fpidpwm_pkg::HIST_FRAC + 1;
	localparam int DigW   = fpidpwm_pkg::DIGIT_W;
	localparam int CoefW  = fpidpwm_pkg::COEF_W;
	localparam int ErrW   = fpidpwm_pkg::ERR_W;
	localparam int PwmW   = fpidpwm_pkg::PWM_W;
	// Digits per error operand and per history operand.
	localparam int NdE    = (ErrW + DigW - 1) / DigW;
	localparam int NdU    = (HistW + DigW - 1) / DigW;
	localparam int EPadW  = NdE * DigW;
	localparam int MrW    = NdU * DigW;
	localparam int DcW    = $clog2(NdU);
	// Product register and accumulator widths.
	localparam int PW     = CoefW + MrW;
	localparam int TermEW = CoefW + ErrW + fpidpwm_pkg::HIST_FRAC;
	localparam int TermUW = CoefW + HistW;
	localparam int SumW0  = ((TermEW > TermUW) ? TermEW : TermUW) + 3;
	localparam int SumW   = (SumW0 > PW) ? SumW0 : PW;
	localparam int UW     = SumW - COEF_FRAC_BITS;
	// Dividend of the duty scaling: magnitude times span.
	localparam int NW     = MagW + PwmW;

	localparam logic signed [UW-1:0] LimHi = UW'(DRIVE_LIMIT) <<< fpidpwm_pkg::HIST_FRAC;
	localparam logic signed [UW-1:0] LimLo = -LimHi;

	fpidpwm_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [fpidpwm_pkg::SETPOINT_W-1:0] setpoint_q;
	logic signed [CoefW-1:0]            coef_b0_q, coef_b1_q, coef_b2_q;
	logic signed [CoefW-1:0]            coef_a1_q, coef_a2_q;
	logic [PwmW-1:0]                    pwm_min_q, pwm_max_q;

	// Controller history.
	logic signed [ErrW-1:0]  e0_q, e1_q, e2_q;
	logic signed [HistW-1:0] u1_q, u2_q;

	// Multiply-accumulate datapath.
	fpidpwm_pkg::term_t      term_q, term_nx;
	logic [DcW-1:0]          dig_q;
	logic [MrW-1:0]          mr_q, mr_nx;
	logic signed [PW-1:0]    p_q, p_nx;
	logic signed [SumW-1:0]  s_q, p_sh;
	logic                    add_pend_q, add_neg_q, add_sh_q;
	logic signed [CoefW-1:0] coef_sel;
	logic signed [DigW:0]    dig_s;
	logic signed [CoefW+DigW:0] dprod;
	logic                    term_is_err, dig_last;
	logic signed [ErrW-1:0]  e0_new;

	// Clamp and scaling.
	logic signed [UW-1:0]     u_full;
	logic signed [HistW-1:0]  u_c;
	logic [HistW-1:0]         abs_u;
	logic [MagW-1:0]          mag_nx, mag_q;
	logic signed [DriveW-1:0] drv_nx, calc_drive_q;
	fpidpwm_pkg::dir_t        dir_nx, calc_dir_q;
	logic signed [PwmW:0]     span;
	logic [PwmW-1:0]          span_abs;
	logic                     span_neg_q;
	logic [NW-1:0]            prod_q, quotient;
	logic [PwmW-1:0]          quo12, duty_nx;

	// Control.
	logic accept, div_start, div_done, out_load;

	// Output register.
	logic                     out_valid_q;
	fpidpwm_pkg::dir_t        res_dir_q;
	logic [PwmW-1:0]          res_duty_q;
	logic signed [DriveW-1:0] res_drive_q;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= fpidpwm_pkg::SETPOINT_RST;
			coef_b0_q  <= fpidpwm_pkg::COEF_B0_RST;
			coef_b1_q  <= fpidpwm_pkg::COEF_B1_RST;
			coef_b2_q  <= fpidpwm_pkg::COEF_B2_RST;
			coef_a1_q  <= fpidpwm_pkg::COEF_A1_RST;
			coef_a2_q  <= fpidpwm_pkg::COEF_A2_RST;
			pwm_min_q  <= fpidpwm_pkg::PWM_MIN_RST;
			pwm_max_q  <= fpidpwm_pkg::PWM_MAX_RST;
		end else if (cfg_wr_en) begin
			case (fpidpwm_pkg::cfg_reg_t'(cfg_index))
				fpidpwm_pkg::REG_SETPOINT: setpoint_q <= cfg_data[fpidpwm_pkg::SETPOINT_W-1:0];
				fpidpwm_pkg::REG_COEF_B0:  coef_b0_q  <= cfg_data;
				fpidpwm_pkg::REG_COEF_B1:  coef_b1_q  <= cfg_data;
				fpidpwm_pkg::REG_COEF_B2:  coef_b2_q  <= cfg_data;
				fpidpwm_pkg::REG_COEF_A1:  coef_a1_q  <= cfg_data;
				fpidpwm_pkg::REG_COEF_A2:  coef_a2_q  <= cfg_data;
				fpidpwm_pkg::REG_PWM_MIN:  pwm_min_q  <= cfg_data[PwmW-1:0];
				fpidpwm_pkg::REG_PWM_MAX:  pwm_max_q  <= cfg_data[PwmW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpidpwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			fpidpwm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = fpidpwm_pkg::ST_MAC;
				end
			end
			fpidpwm_pkg::ST_MAC: begin
				if (dig_last && term_q == fpidpwm_pkg::TERM_A2) begin
					state_d = fpidpwm_pkg::ST_LAST_ADD;
				end
			end
			fpidpwm_pkg::ST_LAST_ADD: state_d = fpidpwm_pkg::ST_CLAMP;
			fpidpwm_pkg::ST_CLAMP:    state_d = fpidpwm_pkg::ST_SCALE;
			fpidpwm_pkg::ST_SCALE:    state_d = fpidpwm_pkg::ST_START;
			fpidpwm_pkg::ST_START: begin
				div_start = 1'b1;
				state_d   = fpidpwm_pkg::ST_DIVIDE;
			end
			fpidpwm_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = fpidpwm_pkg::ST_DONE;
				end
			end
			fpidpwm_pkg::ST_DONE: begin
				// Hand the result over as soon as the output register is free.
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = fpidpwm_pkg::ST_IDLE;
				end
			end
			default: state_d = fpidpwm_pkg::ST_IDLE;
		endcase
	end

	assign accept = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Digit-serial multiply-accumulate.
	// Each term is built most significant digit first in p_q (Horner form): the top
	// digit is signed, the others unsigned. In the cycle after a term's last digit
	// the finished product is added to or subtracted from the accumulator, while the
	// next term's first digit already enters p_q.
	// ------------------------------------------------------------------
	assign e0_new = $signed({1'b0, setpoint_q}) - $signed({1'b0, angle});

	assign term_is_err = (term_q == fpidpwm_pkg::TERM_B0) || (term_q == fpidpwm_pkg::TERM_B1) ||
		(term_q == fpidpwm_pkg::TERM_B2);
	assign dig_last = term_is_err ? (dig_q == DcW'(NdE - 1)) : (dig_q == DcW'(NdU - 1));

	always_comb begin
		case (term_q)
			fpidpwm_pkg::TERM_B0: begin
				coef_sel = coef_b0_q;
				term_nx  = fpidpwm_pkg::TERM_B1;
				mr_nx    = {EPadW'(e1_q), {(MrW - EPadW){1'b0}}};
			end
			fpidpwm_pkg::TERM_B1: begin
				coef_sel = coef_b1_q;
				term_nx  = fpidpwm_pkg::TERM_B2;
				mr_nx    = {EPadW'(e2_q), {(MrW - EPadW){1'b0}}};
			end
			fpidpwm_pkg::TERM_B2: begin
				coef_sel = coef_b2_q;
				term_nx  = fpidpwm_pkg::TERM_A1;
				mr_nx    = MrW'(u1_q);
			end
			fpidpwm_pkg::TERM_A1: begin
				coef_sel = coef_a1_q;
				term_nx  = fpidpwm_pkg::TERM_A2;
				mr_nx    = MrW'(u2_q);
			end
			fpidpwm_pkg::TERM_A2: begin
				coef_sel = coef_a2_q;
				term_nx  = fpidpwm_pkg::TERM_B0;
				mr_nx    = '0;
			end
			default: begin
				coef_sel = '0;
				term_nx  = fpidpwm_pkg::TERM_B0;
				mr_nx    = '0;
			end
		endcase
	end

	assign dig_s = (dig_q == '0) ? $signed({mr_q[MrW-1], mr_q[MrW-1 -: DigW]})
		: $signed({1'b0, mr_q[MrW-1 -: DigW]});
	assign dprod = coef_sel * dig_s;
	assign p_nx  = (dig_q == '0) ? PW'(dprod) : ((p_q <<< DigW) + PW'(dprod));
	// Error terms carry no fraction, so they are aligned to the history's Q.16.
	assign p_sh  = add_sh_q ? (SumW'(p_q) <<< fpidpwm_pkg::HIST_FRAC) : SumW'(p_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q     <= fpidpwm_pkg::TERM_B0;
			dig_q      <= '0;
			add_pend_q <= 1'b0;
		end else if (accept) begin
			term_q     <= fpidpwm_pkg::TERM_B0;
			dig_q      <= '0;
			add_pend_q <= 1'b0;
		end else if (state_q == fpidpwm_pkg::ST_MAC) begin
			add_pend_q <= dig_last;
			if (dig_last) begin
				dig_q  <= '0;
				term_q <= term_nx;
			end else begin
				dig_q <= dig_q + 1'b1;
			end
		end else begin
			add_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q  <= '0;
			mr_q <= {EPadW'(e0_new), {(MrW - EPadW){1'b0}}};
			e0_q <= e0_new;
		end else begin
			if (add_pend_q) begin
				s_q <= add_neg_q ? (s_q - p_sh) : (s_q + p_sh);
			end
			if (state_q == fpidpwm_pkg::ST_MAC) begin
				p_q       <= p_nx;
				add_neg_q <= !term_is_err;
				add_sh_q  <= term_is_err;
				mr_q      <= dig_last ? mr_nx : (mr_q << DigW);
			end
		end
	end

	// ------------------------------------------------------------------
	// Rounding, clamping and history update.
	// Dropping the low fraction bits of the exact sum rounds toward minus infinity.
	// ------------------------------------------------------------------
	assign u_full = $signed(s_q[SumW-1:COEF_FRAC_BITS]);

	always_comb begin
		if (u_full > LimHi) begin
			u_c = HistW'(LimHi);
		end else if (u_full < LimLo) begin
			u_c = HistW'(LimLo);
		end else begin
			u_c = u_full[HistW-1:0];
		end
		abs_u  = u_c[HistW-1] ? HistW'(-u_c) : HistW'(u_c);
		mag_nx = abs_u[HistW-2:fpidpwm_pkg::HIST_FRAC];
		drv_nx = u_c[HistW-1] ? -$signed({1'b0, mag_nx}) : $signed({1'b0, mag_nx});
		if (s_q == '0) begin
			dir_nx = fpidpwm_pkg::DIR_STOP;
		end else if (s_q[SumW-1]) begin
			dir_nx = fpidpwm_pkg::DIR_CCW;
		end else begin
			dir_nx = fpidpwm_pkg::DIR_CW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
			e2_q <= '0;
			u1_q <= '0;
			u2_q <= '0;
		end else if (state_q == fpidpwm_pkg::ST_CLAMP) begin
			e1_q <= e0_q;
			e2_q <= e1_q;
			u1_q <= u_c;
			u2_q <= u1_q;
		end
	end

	// ------------------------------------------------------------------
	// Duty scaling: pwm_min + trunc(mag * |span| / DRIVE_LIMIT), signed by span.
	// ------------------------------------------------------------------
	assign span     = $signed({1'b0, pwm_max_q}) - $signed({1'b0, pwm_min_q});
	assign span_abs = span[PwmW] ? PwmW'(-span) : span[PwmW-1:0];

	always_ff @(posedge clk) begin
		if (state_q == fpidpwm_pkg::ST_CLAMP) begin
			mag_q        <= mag_nx;
			calc_drive_q <= drv_nx;
			calc_dir_q   <= dir_nx;
		end
		if (state_q == fpidpwm_pkg::ST_SCALE) begin
			prod_q     <= NW'(mag_q * span_abs);
			span_neg_q <= span[PwmW];
		end
	end

	fpidpwm_sdiv #(
		.DVD_W   (NW),
		.DIVISOR (DRIVE_LIMIT),
		.REM_W   (MagW)
	) u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.quotient (quotient),
		.done     (div_done)
	);

	// The quotient never exceeds |span|, so its low bits hold all of it.
	assign quo12   = quotient[PwmW-1:0];
	assign duty_nx = span_neg_q ? (pwm_min_q - quo12) : (pwm_min_q + quo12);

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_dir_q   <= calc_dir_q;
			res_duty_q  <= duty_nx;
			res_drive_q <= calc_drive_q;
		end
	end

	assign out_valid = out_valid_q;
	assign direction = res_dir_q;
	assign duty      = res_duty_q;
	assign drive     = res_drive_q;

endmodule

// File: verif/tb.sv
// Self-checking testbench of the filtered PID controller with PWM duty mapping.
`timescale 1ns / 1ps

// The testbench drives angle samples through the input channel and checks every
// result that leaves the output channel against a mirror of the controller kept
// here. The mirror holds its own copy of the registers and the history.
//
// Flow:
// - Reset is held at the start. A short directed run then uses the register
//   defaults. It covers an exactly zero sum, the angle extremes and single bits.
// - A series of phases follows. Before each phase, once the block has drained,
//   all eight registers are rewritten. The settings are full positive and full
//   negative coefficients (saturation on both sides), zero coefficients (always
//   stop), tiny coefficients (fractional sums that truncate to a zero drive), the
//   defaults, a setpoint beyond 359, a downward and a flat duty mapping, and
//   random coefficients of random magnitude.
// - Most angles sit near the setpoint, as they would in a closed loop. The rest
//   span the whole 9-bit field.
// Both channels idle at random, with some phases free of gaps. Twice the
// receiver holds off for a long stretch while the sender keeps offering
// transactions, so that the block fills up and stalls its input.

module tb;

	localparam int DRIVE_W     = $clog2(fpidpwm_pkg::DRIVE_LIMIT_DEF + 1) + 1;
	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 80;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 500;
	localparam longint ONE     = 64'sd1 <<< fpidpwm_pkg::HIST_FRAC;
	localparam longint SAT     = longint'(fpidpwm_pkg::DRIVE_LIMIT_DEF) <<< fpidpwm_pkg::HIST_FRAC;

	typedef struct packed {
		fpidpwm_pkg::dir_t                direction;
		logic [fpidpwm_pkg::PWM_W-1:0]    duty;
		logic signed [DRIVE_W-1:0]        drive;
	} control_result_t;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  cfg_wr_en = 1'b0;
	logic [fpidpwm_pkg::CFG_IDX_W-1:0]     cfg_index = fpidpwm_pkg::REG_SETPOINT;
	logic [fpidpwm_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
	logic                                  in_valid = 1'b0;
	logic                                  in_ready;
	logic [fpidpwm_pkg::ANGLE_W-1:0]       angle = '0;
	logic                                  out_valid;
	logic                                  out_ready = 1'b0;
	logic [fpidpwm_pkg::DIR_W-1:0]         direction;
	logic [fpidpwm_pkg::PWM_W-1:0]         duty;
	logic signed [DRIVE_W-1:0]             drive;

	filtered_pid_pwm_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.direction (direction),
		.duty      (duty),
		.drive     (drive)
	);

	// Angles waiting to be sent, and results the controller still owes us.
	logic [fpidpwm_pkg::ANGLE_W-1:0] angle_backlog[$];
	control_result_t                 expected_results[$];

	// Handshake flags, set at the rising edge and read at the next falling edge.
	bit in_taken;
	bit out_taken;

	// Per-phase switches that remove the random gaps on either side.
	bit in_burst;
	bit out_burst;

	int mismatches;
	int cycles;

	// Mirror of the configuration registers.
	logic [fpidpwm_pkg::SETPOINT_W-1:0]    sp_reg;
	logic signed [fpidpwm_pkg::COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
	logic [fpidpwm_pkg::PWM_W-1:0]         pwm_lo_reg, pwm_hi_reg;

	// Mirror of the controller history: integer errors and clamped outputs that
	// carry HIST_FRAC fraction bits.
	longint err_prev, err_prev2;
	longint u_prev, u_prev2;

	initial begin
		forever #10 clk = ~clk;
	end

	// Evaluates one controller step for a sample and queues the result it owes.
	// The sum is formed exactly with COEF_FRAC_BITS + HIST_FRAC fraction bits;
	// the arithmetic shift then floors it to HIST_FRAC fraction bits.
	task automatic compute_control(input logic [fpidpwm_pkg::ANGLE_W-1:0] sample);
		longint err, acc, u, mag, drive_full;
		int span, scaled, duty_full;
		control_result_t res;
		err = longint'(sp_reg) - longint'(sample);
		acc = longint'(b0_reg) * err * ONE + longint'(b1_reg) * err_prev * ONE
			+ longint'(b2_reg) * err_prev2 * ONE
			- longint'(a1_reg) * u_prev - longint'(a2_reg) * u_prev2;
		// The direction follows the sign of the exact sum, fraction included.
		if (acc > 0)
			res.direction = fpidpwm_pkg::DIR_CW;
		else if (acc < 0)
			res.direction = fpidpwm_pkg::DIR_CCW;
		else
			res.direction = fpidpwm_pkg::DIR_STOP;
		u = acc >>> fpidpwm_pkg::COEF_FRAC_BITS_DEF;
		if (u > SAT)
			u = SAT;
		else if (u < -SAT)
			u = -SAT;
		// Truncation toward zero of the clamped output.
		mag = (u < 0 ? -u : u) >>> fpidpwm_pkg::HIST_FRAC;
		drive_full = u < 0 ? -mag : mag;
		res.drive = drive_full[DRIVE_W-1:0];
		span = int'(pwm_hi_reg) - int'(pwm_lo_reg);
		if (span >= 0)
			scaled = (int'(mag) * span) / fpidpwm_pkg::DRIVE_LIMIT_DEF;
		else
			scaled = -((int'(mag) * -span) / fpidpwm_pkg::DRIVE_LIMIT_DEF);
		duty_full = int'(pwm_lo_reg) + scaled;
		res.duty = duty_full[fpidpwm_pkg::PWM_W-1:0];
		expected_results.push_back(res);
		err_prev2 = err_prev;
		err_prev = err;
		u_prev2 = u_prev;
		u_prev = u;
	endtask

	// Monitor: mirrors register writes, predicts on each input transaction and
	// checks each output transaction against the oldest prediction.
	always @(posedge clk) begin
		control_result_t want;
		in_taken = 1'b0;
		out_taken = 1'b0;
		if (!arst_n) begin
			sp_reg = fpidpwm_pkg::SETPOINT_RST;
			b0_reg = fpidpwm_pkg::COEF_B0_RST;
			b1_reg = fpidpwm_pkg::COEF_B1_RST;
			b2_reg = fpidpwm_pkg::COEF_B2_RST;
			a1_reg = fpidpwm_pkg::COEF_A1_RST;
			a2_reg = fpidpwm_pkg::COEF_A2_RST;
			pwm_lo_reg = fpidpwm_pkg::PWM_MIN_RST;
			pwm_hi_reg = fpidpwm_pkg::PWM_MAX_RST;
			err_prev = 0;
			err_prev2 = 0;
			u_prev = 0;
			u_prev2 = 0;
		end else begin
			if (cfg_wr_en) begin
				case (fpidpwm_pkg::cfg_reg_t'(cfg_index))
					fpidpwm_pkg::REG_SETPOINT:
						sp_reg = cfg_data[fpidpwm_pkg::SETPOINT_W-1:0];
					fpidpwm_pkg::REG_COEF_B0:  b0_reg = cfg_data;
					fpidpwm_pkg::REG_COEF_B1:  b1_reg = cfg_data;
					fpidpwm_pkg::REG_COEF_B2:  b2_reg = cfg_data;
					fpidpwm_pkg::REG_COEF_A1:  a1_reg = cfg_data;
					fpidpwm_pkg::REG_COEF_A2:  a2_reg = cfg_data;
					fpidpwm_pkg::REG_PWM_MIN:  pwm_lo_reg = cfg_data[fpidpwm_pkg::PWM_W-1:0];
					fpidpwm_pkg::REG_PWM_MAX:  pwm_hi_reg = cfg_data[fpidpwm_pkg::PWM_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				compute_control(angle);
			end
			if (out_valid && out_ready) begin
				out_taken = 1'b1;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: dir %0d duty %0d drive %0d",
							direction, duty, drive);
				end else begin
					want = expected_results.pop_front();
					if (direction !== want.direction || duty !== want.duty
							|| drive !== want.drive) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: dir %0d/%0d duty %0d/%0d drive %0d/%0d (exp/got)",
								want.direction, direction, want.duty, duty,
								want.drive, drive);
					end
				end
			end
		end
	end

	// Driver: offers the backlog one transaction at a time. After each accepted
	// transaction it draws a gap; with a zero gap valid simply stays high.
	int send_gap;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_taken)
				send_gap = in_burst ? 0 : $urandom_range(0, 13);
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (angle_backlog.size() != 0) begin
				angle <= angle_backlog.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: after each accepted result it stalls for a random number of
	// cycles. At two fixed points it holds off for a long stretch instead, which
	// backs the block up while the driver keeps offering samples.
	int stall_left;
	int results_taken;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_taken) begin
				results_taken++;
				if (results_taken == 400 || results_taken == 850)
					stall_left = LONG_HOLD;
				else
					stall_left = out_burst ? 0 : $urandom_range(0, 13);
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Register write on the configuration port, one per falling edge.
	task automatic write_reg(input fpidpwm_pkg::cfg_reg_t idx,
			input logic [fpidpwm_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	// Returns once every sample is sent and every result has come back. The test
	// runs at the rising edge, where the handshake signals are settled.
	task automatic wait_drained();
		while (angle_backlog.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Random coefficient of random magnitude: a full-range word shifted down.
	function automatic logic [fpidpwm_pkg::CFG_DATA_W-1:0] random_coef();
		return $signed($urandom) >>> $urandom_range(0, 31);
	endfunction

	// Sample near the setpoint most of the time, as a closed loop would see.
	function automatic logic [fpidpwm_pkg::ANGLE_W-1:0] pick_angle(input int target);
		int a;
		if ($urandom_range(0, 9) < 6) begin
			a = target + $urandom_range(0, 40) - 20;
			if (a < 0)
				a = 0;
			if (a > 511)
				a = 511;
		end else begin
			a = $urandom_range(0, 511);
		end
		return a[fpidpwm_pkg::ANGLE_W-1:0];
	endfunction

	initial begin
		logic [fpidpwm_pkg::CFG_DATA_W-1:0] coef[5];
		int sp, pwm_lo, pwm_hi;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run on the reset defaults. Starting at the setpoint with an
		// empty history gives an exactly zero sum: stop at the minimum duty.
		in_burst = 1'b0;
		out_burst = 1'b0;
		foreach (coef[k])
			coef[k] = '0;
		angle_backlog = '{9'd330, 9'd330, 9'd0, 9'd359, 9'd511, 9'd256, 9'd1,
			9'd2, 9'd4, 9'd8, 9'd16, 9'd32, 9'd64, 9'd128, 9'd330, 9'd330,
			9'd329, 9'd331, 9'd200, 9'd400};
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					// Full positive gains against a zero setpoint: saturation.
					sp = 0;
					foreach (coef[k])
						coef[k] = 32'h7FFF_FFFF;
					pwm_lo = 0;
					pwm_hi = 4095;
				end
				1: begin
					// Full negative gains, setpoint beyond 359, downward mapping.
					sp = 511;
					foreach (coef[k])
						coef[k] = 32'h8000_0000;
					pwm_lo = 4095;
					pwm_hi = 0;
				end
				2: begin
					// No gain at all: every sum is zero, a flat duty.
					sp = 359;
					foreach (coef[k])
						coef[k] = '0;
					pwm_lo = 1234;
					pwm_hi = 1234;
				end
				3: begin
					// Tiny gains: sums below one unit that still set a direction.
					sp = $urandom_range(0, 359);
					foreach (coef[k])
						coef[k] = $urandom_range(0, 16) - 8;
					pwm_lo = 0;
					pwm_hi = 4095;
				end
				4: begin
					sp = int'(fpidpwm_pkg::SETPOINT_RST);
					coef[0] = fpidpwm_pkg::COEF_B0_RST;
					coef[1] = fpidpwm_pkg::COEF_B1_RST;
					coef[2] = fpidpwm_pkg::COEF_B2_RST;
					coef[3] = fpidpwm_pkg::COEF_A1_RST;
					coef[4] = fpidpwm_pkg::COEF_A2_RST;
					pwm_lo = int'(fpidpwm_pkg::PWM_MIN_RST);
					pwm_hi = int'(fpidpwm_pkg::PWM_MAX_RST);
				end
				default: begin
					sp = $urandom_range(0, 511);
					foreach (coef[k])
						coef[k] = random_coef();
					pwm_lo = $urandom_range(0, 4095);
					pwm_hi = $urandom_range(0, 4095);
				end
			endcase

			// The block is idle here; a short pause before touching registers.
			repeat (4) @(posedge clk);
			write_reg(fpidpwm_pkg::REG_SETPOINT, sp);
			write_reg(fpidpwm_pkg::REG_COEF_B0, coef[0]);
			write_reg(fpidpwm_pkg::REG_COEF_B1, coef[1]);
			write_reg(fpidpwm_pkg::REG_COEF_B2, coef[2]);
			write_reg(fpidpwm_pkg::REG_COEF_A1, coef[3]);
			write_reg(fpidpwm_pkg::REG_COEF_A2, coef[4]);
			write_reg(fpidpwm_pkg::REG_PWM_MIN, pwm_lo);
			write_reg(fpidpwm_pkg::REG_PWM_MAX, pwm_hi);
			@(negedge clk);
			cfg_wr_en <= 1'b0;
			@(posedge clk);

			in_burst = ($urandom_range(0, 4) == 0);
			out_burst = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++)
				angle_backlog.push_back(pick_angle(sp));
			wait_drained();
		end

		// Let a full processing time pass so that a stray result would show up.
		repeat (80) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
